>>> hdl/esdm_pkg.sv
// shared widths, codes and reset values for the encoder speed and direction meter
// no dependencies
package esdm_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned FracW   = 8;
  localparam int unsigned AvgW    = TickW + FracW;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 64;

  localparam logic [CountW-1:0] PprReset = CountW'(1000);

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_A    = 2'd1,
    CH_B    = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PEND = 3'b100
  } state_e;

endpackage

>>> hdl/esdm_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on esdm_pkg for default widths
module esdm_div #(
  parameter int unsigned DVD_W = esdm_pkg::AvgW,
  parameter int unsigned DVS_W = esdm_pkg::CountW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);
  import esdm_pkg::*;

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // shift in the next dividend bit and try a subtraction
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(DVD_W);
    end else if (cnt_q != '0) begin
      dvd_d  = {dvd_q[DVD_W-2:0], ge};
      rem_d  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

>>> hdl/encoder_speed_direction_meter.sv
// Encoder speed and direction meter, top level.
// Input stream: one transaction per level change on quadrature channel A or B.
//   s_axis_tuser selects the channel, s_axis_tdata carries the new level and a
//   wrapping 32-bit microsecond timestamp.
// Output stream: exactly one transaction per input transaction, in order, with
//   the direction, average period (8 fraction bits), pulse position and, in
//   m_axis_tuser, a flag set when that change closed a revolution.
// cfg_we_i writes pulses per revolution (reset 1000); write only while idle.
// Timing: an ordinary change goes from ST_IDLE through ST_PEND to the result
//   register, and the input is ready again once the result register takes it.
//   A change that closes a revolution runs the bit-serial divider, 40 steps
//   one quotient bit each, in ST_DIV before ST_PEND and the result register;
//   the divider sets the worst-case rate.
// One item is worked on at a time; s_axis_tready is high only when idle.
// A result waiting on a stalled receiver does not block acceptance of the next
//   item, which then holds in its final state until the output register frees.
// Reset clears all measuring state, disarms the block and empties the output;
//   nothing is counted until the first rising edge of channel A.
module encoder_speed_direction_meter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tuser: pin_is_b
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: pin_level [0], timestamp [32:1], zero pad
  input  logic [esdm_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: reversed [0], avg_period [40:1], pulse_position [56:41], zero pad
  output logic [esdm_pkg::OutDataW-1:0]    m_axis_tdata,
  // tuser: rev_done
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [esdm_pkg::CountW-1:0]      cfg_wdata_i
);
  import esdm_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   ppr_q;
  logic                armed_q, armed_d;
  logic                lvl_a_q, lvl_a_d;
  logic                lvl_b_q, lvl_b_d;
  chan_e               last_q, last_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [TickW-1:0]    prev_q, prev_d;
  logic [TickW-1:0]    sum_q, sum_d;
  logic                rev_q, rev_d;
  logic                done_q, done_d;
  logic [AvgW-1:0]     avg_q, avg_d;
  logic                ovalid_q, ovalid_d;
  logic [OutDataW-1:0] odata_q, odata_d;
  logic                ouser_q, ouser_d;

  logic                accept;
  logic                is_b;
  logic                lvl;
  logic [TickW-1:0]    tick;
  chan_e               chan;
  logic                a_rise;
  logic [CountW-1:0]   count_inc;
  logic [TickW-1:0]    delta;
  logic                div_start;
  logic                div_done;
  logic [AvgW-1:0]     div_quot;
  logic                out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_b      = s_axis_tuser;
  assign lvl       = s_axis_tdata[0];
  assign tick      = s_axis_tdata[TickW:1];
  assign chan      = is_b ? CH_B : CH_A;
  assign a_rise    = !is_b && lvl;
  assign count_inc = count_q + CountW'(1);
  assign delta     = tick - prev_q;
  assign out_free  = !ovalid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    armed_d   = armed_q;
    lvl_a_d   = lvl_a_q;
    lvl_b_d   = lvl_b_q;
    last_d    = last_q;
    count_d   = count_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    rev_d     = rev_q;
    done_d    = done_q;
    avg_d     = avg_q;
    div_start = 1'b0;
    ovalid_d  = ovalid_q && !m_axis_tready;
    odata_d   = odata_q;
    ouser_d   = ouser_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d  = 1'b0;
          state_d = ST_PEND;
          if (!armed_q) begin
            if (a_rise) begin
              prev_d  = tick;
              armed_d = 1'b1;
            end
          end else begin
            // direction is only sampled at the start of a revolution
            if (count_q == '0) begin
              if (is_b) begin
                lvl_b_d = lvl;
              end else begin
                lvl_a_d = lvl;
              end
              // debounce: only a change on the other channel counts
              if (chan != last_q) begin
                last_d = chan;
                if (a_rise) begin
                  if (lvl_b_q) begin
                    rev_d = 1'b0;
                  end
                end else if (is_b && lvl) begin
                  if (lvl_a_q) begin
                    rev_d = 1'b1;
                  end
                end
              end
            end
            if (a_rise) begin
              prev_d = tick;
              if (ppr_q != '0 && count_inc == ppr_q) begin
                // average uses the total before this edge's delta
                count_d   = '0;
                sum_d     = delta;
                done_d    = 1'b1;
                div_start = 1'b1;
                state_d   = ST_DIV;
              end else begin
                count_d = count_inc;
                sum_d   = sum_q + delta;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = div_quot;
          state_d = ST_PEND;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = OutDataW'({count_q, avg_q, rev_q});
          ouser_d  = done_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  esdm_div #(
    .DVD_W(AvgW),
    .DVS_W(CountW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_q, {FracW{1'b0}}}),
    .divisor_i (ppr_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ppr_q    <= PprReset;
      armed_q  <= 1'b0;
      lvl_a_q  <= 1'b0;
      lvl_b_q  <= 1'b0;
      last_q   <= CH_NONE;
      count_q  <= '0;
      prev_q   <= '0;
      sum_q    <= '0;
      rev_q    <= 1'b0;
      done_q   <= 1'b0;
      avg_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        ppr_q <= cfg_wdata_i;
      end
      armed_q  <= armed_d;
      lvl_a_q  <= lvl_a_d;
      lvl_b_q  <= lvl_b_d;
      last_q   <= last_d;
      count_q  <= count_d;
      prev_q   <= prev_d;
      sum_q    <= sum_d;
      rev_q    <= rev_d;
      done_q   <= done_d;
      avg_q    <= avg_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule

>>> hdl/esdm_chk.sv
// port-level checks for the encoder speed and direction meter
// depends on esdm_pkg; bound to encoder_speed_direction_meter below
module esdm_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [esdm_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import esdm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  // a completed revolution restarts the pulse position
  a_rev_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[AvgW+CountW:AvgW+1] == '0)
    else $error("revolution reported with non-zero pulse position");

  // the input is never ready in the cycle after an accepted transaction
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // a new result only appears after an item has been worked on
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output appeared without pending work");

  // a channel B change never closes a revolution
  a_b_no_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> ##1
      !($rose(m_axis_tvalid) && m_axis_tuser))
    else $error("channel B change reported a revolution");

endmodule

bind encoder_speed_direction_meter esdm_chk u_esdm_chk (.*);
